FILE: design/gauss_jordan_scaled_pivot_solver_macros.svh
// Assertion macros shared by the solver modules.
// No dependencies; included by the files that carry concurrent checks.
`ifndef GAUSS_JORDAN_SCALED_PIVOT_SOLVER_MACROS_SVH
`define GAUSS_JORDAN_SCALED_PIVOT_SOLVER_MACROS_SVH
`ifndef SYNTHESIS
`define GJS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);
`define GJS_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error(msg);
`else
`define GJS_ASSERT(lbl, clk, rst, prop, msg)
`define GJS_ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

FILE: design/gjsps_pkg.sv
// Shared constants, datapath operation codes and status struct of the solver.
// No dependencies.
package gjsps_pkg;

   localparam int MAX_UNKNOWNS_DEF = 8;

   localparam int ROW_FIELD_W = 3;
   localparam int COL_FIELD_W = 4;
   localparam int VALUE_W     = 32;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 4;
   localparam int TOL_W       = 16;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 40;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   localparam int DIVIDEND_W = 64;
   localparam int DIVISOR_W  = 32;
   localparam int QUOT_W     = 34;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_SOLVE = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNKNOWN_COUNT = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_TOL      = 1'b1;

   localparam logic [STATUS_W-1:0] ST_SOLVED     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_ANSWER  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_SINGULAR   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NO_UNKNOWN = 2'd3;

   localparam logic [VALUE_W-1:0] ONE_Q16 = 32'h0001_0000;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_SOLVE_INIT,
      OP_NEXT_ROW,
      OP_SCALE_INIT,
      OP_RD_IJ,
      OP_SCALE_ACC,
      OP_RD_IC,
      OP_RATIO_START,
      OP_RATIO_CMP,
      OP_PIVOT_TAKE,
      OP_RD_PC,
      OP_LATCH_PIV,
      OP_STEP_NEXT,
      OP_LATCH_F,
      OP_RD_PJ,
      OP_LATCH_PJ,
      OP_MUL,
      OP_ELIM_START,
      OP_ELIM_WRITE,
      OP_CLEAN_INIT,
      OP_CL_CHECK,
      OP_CL_ROW_END,
      OP_FIN_INIT,
      OP_EMIT_NOUNK,
      OP_RD_IN,
      OP_LATCH_RHS,
      OP_FIN_START,
      OP_FIN_WRITE_RHS,
      OP_FIN_WRITE_COEF,
      OP_EMIT_SING,
      OP_EMIT_NOANS
   } dp_op_type;

   typedef struct packed {
      logic i_end;
      logic j_end_coef;
      logic j_end_all;
      logic row_used_cur;
      logic row_is_pivot;
      logic last_step;
      logic found;
      logic scale_zero;
      logic multi_coef;
      logic row_hit_cur;
      logic div_busy;
      logic div_done;
      logic out_busy;
   } dp_status_type;

endpackage

FILE: design/gauss_jordan_scaled_pivot_solver.sv
// Channel  Handshake                 Payload
// req      req_tvalid / req_tready   tuser kind, tdata row, column, element value
// rsp      rsp_tvalid / rsp_tready   tuser status, tlast last result, tdata index, value
// csr      csr_valid / csr_ready     csr_index register, csr_data value
// A solve item's run time is set by the shared 34-step divider and the single-read-port
// matrix RAM, and grows with each updated matrix element, each pivot candidate and each
// column it scans.
// Reset is synchronous, active high; the matrix RAM holds its contents.
// req_tready is low while a solve runs; a stalled result holds the sequencer.
// Top level of the scaled-pivot Gauss-Jordan solver; depends on gjsps_pkg,
// gjsps_ctrl and gjsps_dp.
module gauss_jordan_scaled_pivot_solver #(
   parameter int MAX_UNKNOWNS = gjsps_pkg::MAX_UNKNOWNS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [gjsps_pkg::REQ_DATA_W-1:0]    req_tdata,  // row_index, column_index, element_value
   input  logic                                req_tuser,  // kind
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [gjsps_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // unknown_index, solution_value
   output logic [gjsps_pkg::STATUS_W-1:0]      rsp_tuser,  // status
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gjsps_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [gjsps_pkg::CSR_DATA_W-1:0]    csr_data
);

   gjsps_pkg::dp_op_type     op;
   gjsps_pkg::dp_status_type status;
   logic [gjsps_pkg::ROW_FIELD_W-1:0]    out_idx;
   logic signed [gjsps_pkg::VALUE_W-1:0] out_val;

   assign csr_ready = 1'b1;

   gjsps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_kind  (req_tuser),
      .status    (status),
      .op        (op)
   );

   gjsps_dp #(.MAX_UNKNOWNS(MAX_UNKNOWNS)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .op                 (op),
      .status             (status),
      .csr_write          (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_row_index      (req_tdata[2:0]),
      .req_column_index   (req_tdata[6:3]),
      .req_element_value  (req_tdata[38:7]),
      .rsp_valid          (rsp_tvalid),
      .rsp_ready          (rsp_tready),
      .rsp_unknown_index  (out_idx),
      .rsp_solution_value (out_val),
      .rsp_status         (rsp_tuser),
      .rsp_last_result    (rsp_tlast)
   );

   assign rsp_tdata = {5'b0, out_val, out_idx};

endmodule

FILE: design/gjsps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gjsps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 72
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/gjsps_div.sv
// Restoring divider, one quotient bit per cycle, with early overflow flag.
// Depends on gjsps_pkg and the assertion macro header.
`include "gauss_jordan_scaled_pivot_solver_macros.svh"
module gjsps_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [gjsps_pkg::DIVIDEND_W-1:0]  dividend,
   input  logic [gjsps_pkg::DIVISOR_W-1:0]   divisor,
   output logic                              busy,
   output logic                              done,
   output logic [gjsps_pkg::QUOT_W-1:0]      quotient,
   output logic                              overflow
);

   localparam int QW    = gjsps_pkg::QUOT_W;
   localparam int DW    = gjsps_pkg::DIVISOR_W;
   localparam int CNT_W = $clog2(QW + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [QW-1:0]    low_ff, low_in;
   logic [DW-1:0]    dvs_ff, dvs_in;
   logic             ovf_ff, ovf_in;
   logic [DW:0]      trial;
   logic             ge;

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      dvs_in  = dvs_ff;
      ovf_in  = ovf_ff;
      trial   = {rem_ff, low_ff[QW-1]};
      ge      = trial >= {1'b0, dvs_ff};
      if (start) begin
         dvs_in = divisor;
         rem_in = DW'(dividend[gjsps_pkg::DIVIDEND_W-1:QW]);
         low_in = dividend[QW-1:0];
         cnt_in = CNT_W'(QW);
         // quotient would need more than QW bits: report at once
         ovf_in = DW'(dividend[gjsps_pkg::DIVIDEND_W-1:QW]) >= divisor;
         busy_in = !ovf_in;
         done_in = ovf_in;
      end else if (busy_ff) begin
         rem_in = ge ? DW'(trial - {1'b0, dvs_ff}) : trial[DW-1:0];
         low_in = {low_ff[QW-2:0], ge};
         cnt_in = CNT_W'(cnt_ff - 1'b1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      dvs_ff <= dvs_in;
      ovf_ff <= ovf_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = low_ff;
   assign overflow = ovf_ff;

   `GJS_ASSERT_NEVER(a_div_busy_done, clock, reset, busy_ff && done_ff, "divider busy and done")
   `GJS_ASSERT(a_div_rem_bound, clock, reset, busy_ff |-> (rem_ff < dvs_ff), "remainder not below divisor")
   `GJS_ASSERT(a_div_start, clock, reset, start |=> (busy_ff || done_ff), "divider start lost")

endmodule

FILE: design/gjsps_dp.sv
// Solver datapath: matrix RAM, counters, pivot search, multiply, divide and result register.
// Depends on gjsps_pkg, gjsps_ram and gjsps_div.
module gjsps_dp #(
   parameter int MAX_UNKNOWNS = gjsps_pkg::MAX_UNKNOWNS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  gjsps_pkg::dp_op_type                   op,
   output gjsps_pkg::dp_status_type               status,
   input  logic                                   csr_write,
   input  logic [gjsps_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [gjsps_pkg::CSR_DATA_W-1:0]       csr_data,
   input  logic [gjsps_pkg::ROW_FIELD_W-1:0]      req_row_index,
   input  logic [gjsps_pkg::COL_FIELD_W-1:0]      req_column_index,
   input  logic signed [gjsps_pkg::VALUE_W-1:0]   req_element_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [gjsps_pkg::ROW_FIELD_W-1:0]      rsp_unknown_index,
   output logic signed [gjsps_pkg::VALUE_W-1:0]   rsp_solution_value,
   output logic [gjsps_pkg::STATUS_W-1:0]         rsp_status,
   output logic                                   rsp_last_result
);

   localparam int NCOLS  = MAX_UNKNOWNS + 1;
   localparam int DEPTH  = MAX_UNKNOWNS * NCOLS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int ROW_W  = $clog2(MAX_UNKNOWNS);
   localparam int CW     = $clog2(MAX_UNKNOWNS + 2);
   localparam int VW     = gjsps_pkg::VALUE_W;
   localparam int QW     = gjsps_pkg::QUOT_W;
   localparam logic signed [VW-1:0] VAL_MAX = {1'b0, {(VW-1){1'b1}}};
   localparam logic signed [VW-1:0] VAL_MIN = {1'b1, {(VW-1){1'b0}}};

   function automatic logic [VW-1:0] mag32(input logic [VW-1:0] v);
      mag32 = v[VW-1] ? VW'(-v) : v;
   endfunction

   function automatic logic signed [VW-1:0] sat36(input logic signed [QW+1:0] v);
      if (v > (QW+2)'(VAL_MAX)) sat36 = VAL_MAX;
      else if (v < (QW+2)'(VAL_MIN)) sat36 = VAL_MIN;
      else sat36 = v[VW-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [CW-1:0] r,
                                                   input logic [CW-1:0] cc);
      cell_addr = ADDR_W'(32'(r) * NCOLS + 32'(cc));
   endfunction

   // configuration
   logic [gjsps_pkg::COUNT_W-1:0] unknown_count_ff, unknown_count_in;
   logic [gjsps_pkg::TOL_W-1:0]   zero_tol_ff, zero_tol_in;

   // control state
   logic [CW-1:0]           n_ff, n_in, i_ff, i_in, j_ff, j_in, c_ff, c_in, p_ff, p_in;
   logic [MAX_UNKNOWNS-1:0] row_used_ff, row_used_in;
   logic [MAX_UNKNOWNS-1:0] row_hit_ff, row_hit_in;
   logic                    found_ff, found_in;
   logic [1:0]              cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // payload
   logic [VW-1:0]           scale_ff, scale_in, best_ff, best_in;
   logic signed [VW-1:0]    piv_ff, piv_in, f_ff, f_in, prow_ff, prow_in;
   logic signed [VW-1:0]    elem_ff, elem_in, rhs_ff, rhs_in;
   logic [2*VW-1:0]         prod_ff, prod_in;
   logic                    neg_ff, neg_in;
   logic [CW-1:0]           cur_col_ff, cur_col_in;
   logic [CW-1:0]           row_col_ff [MAX_UNKNOWNS];
   logic [CW-1:0]           row_col_in [MAX_UNKNOWNS];
   logic [gjsps_pkg::ROW_FIELD_W-1:0] out_idx_ff, out_idx_in;
   logic signed [VW-1:0]    out_val_ff, out_val_in;
   logic [gjsps_pkg::STATUS_W-1:0] out_st_ff, out_st_in;
   logic                    out_last_ff, out_last_in;

   // RAM and divider
   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
   logic [VW-1:0]        ram_wdata, ram_rdata;
   logic                 div_start;
   logic [gjsps_pkg::DIVIDEND_W-1:0] div_dividend;
   logic [VW-1:0]        div_divisor;
   logic                 div_busy, div_done, div_ovf;
   logic [QW-1:0]        div_q;

   logic [CW-1:0]        n_eff;
   logic [ROW_W-1:0]     i_row, p_row;
   logic [VW-1:0]        mag_rd, mag_piv, ratio;
   logic signed [QW+1:0] delta, diff;
   logic signed [VW-1:0] elim_res, fin_res;
   logic                 last_row;
   logic                 out_busy;

   gjsps_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_matrix (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   gjsps_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q),
      .overflow (div_ovf)
   );

   assign i_row    = i_ff[ROW_W-1:0];
   assign p_row    = p_ff[ROW_W-1:0];
   assign mag_rd   = mag32(ram_rdata);
   assign mag_piv  = mag32(piv_ff);
   assign ratio    = (scale_ff == '0) ? '0 : div_q[VW-1:0];
   assign last_row = i_ff == CW'(n_ff - 1'b1);
   assign out_busy = rsp_valid_ff && !rsp_ready;

   always_comb begin
      if (unknown_count_ff == '0) n_eff = CW'(1);
      else if (32'(unknown_count_ff) > MAX_UNKNOWNS) n_eff = CW'(MAX_UNKNOWNS);
      else n_eff = CW'(unknown_count_ff);
   end

   // elimination and final-result updates, saturated; a too-wide quotient always saturates
   always_comb begin
      delta = neg_ff ? -$signed({2'b00, div_q}) : $signed({2'b00, div_q});
      diff  = (QW+2)'(elem_ff) - delta;
      if (div_ovf) elim_res = neg_ff ? VAL_MAX : VAL_MIN;
      else elim_res = sat36(diff);
      if (div_ovf) fin_res = neg_ff ? VAL_MIN : VAL_MAX;
      else fin_res = sat36(delta);
   end

   // RAM read address
   always_comb begin
      case (op)
         gjsps_pkg::OP_RD_IC:     ram_raddr = cell_addr(i_ff, c_ff);
         gjsps_pkg::OP_RD_PC:     ram_raddr = cell_addr(p_ff, c_ff);
         gjsps_pkg::OP_RD_PJ:     ram_raddr = cell_addr(p_ff, j_ff);
         gjsps_pkg::OP_RD_IN:     ram_raddr = cell_addr(i_ff, n_ff);
         gjsps_pkg::OP_LATCH_RHS: ram_raddr = cell_addr(i_ff, row_col_ff[i_row]);
         default:                 ram_raddr = cell_addr(i_ff, j_ff);
      endcase
   end

   // RAM write port and divider operands
   always_comb begin
      ram_we       = 1'b0;
      ram_waddr    = cell_addr(i_ff, j_ff);
      ram_wdata    = elim_res;
      div_start    = 1'b0;
      div_dividend = prod_ff + {{(VW+1){1'b0}}, mag_piv[VW-1:1]};
      div_divisor  = mag_piv;
      case (op)
         gjsps_pkg::OP_LOAD: begin
            ram_we    = (32'(req_row_index) < MAX_UNKNOWNS) &&
                        (32'(req_column_index) <= MAX_UNKNOWNS);
            ram_waddr = ADDR_W'(32'(req_row_index) * NCOLS + 32'(req_column_index));
            ram_wdata = req_element_value;
         end
         gjsps_pkg::OP_RATIO_START: begin
            div_start    = scale_ff != '0;
            div_dividend = {1'b0, mag_rd, {(VW-1){1'b0}}};
            div_divisor  = scale_ff;
         end
         gjsps_pkg::OP_ELIM_START: begin
            div_start = 1'b1;
         end
         gjsps_pkg::OP_ELIM_WRITE: begin
            ram_we = 1'b1;
         end
         gjsps_pkg::OP_CL_CHECK: begin
            ram_we    = mag_rd <= VW'(zero_tol_ff);
            ram_wdata = '0;
         end
         gjsps_pkg::OP_FIN_START: begin
            div_start    = 1'b1;
            div_dividend = {16'b0, mag32(rhs_ff), 16'b0} +
                           {{(VW+1){1'b0}}, mag_rd[VW-1:1]};
            div_divisor  = mag_rd;
         end
         gjsps_pkg::OP_FIN_WRITE_RHS: begin
            ram_we    = 1'b1;
            ram_waddr = cell_addr(i_ff, n_ff);
            ram_wdata = fin_res;
         end
         gjsps_pkg::OP_FIN_WRITE_COEF: begin
            ram_we    = 1'b1;
            ram_waddr = cell_addr(i_ff, row_col_ff[i_row]);
            ram_wdata = gjsps_pkg::ONE_Q16;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
   end

   // register updates per operation
   always_comb begin
      unknown_count_in = unknown_count_ff;
      zero_tol_in      = zero_tol_ff;
      n_in = n_ff;
      i_in = i_ff;
      j_in = j_ff;
      c_in = c_ff;
      p_in = p_ff;
      row_used_in = row_used_ff;
      row_hit_in  = row_hit_ff;
      found_in    = found_ff;
      cnt_in      = cnt_ff;
      scale_in    = scale_ff;
      best_in     = best_ff;
      piv_in      = piv_ff;
      f_in        = f_ff;
      prow_in     = prow_ff;
      elem_in     = elem_ff;
      rhs_in      = rhs_ff;
      prod_in     = prod_ff;
      neg_in      = neg_ff;
      cur_col_in  = cur_col_ff;
      row_col_in  = row_col_ff;
      out_idx_in  = out_idx_ff;
      out_val_in  = out_val_ff;
      out_st_in   = out_st_ff;
      out_last_in = out_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (csr_write) begin
         case (csr_index)
            gjsps_pkg::CSR_UNKNOWN_COUNT:
               unknown_count_in = csr_data[gjsps_pkg::COUNT_W-1:0];
            gjsps_pkg::CSR_ZERO_TOL: zero_tol_in = csr_data;
            default: zero_tol_in = zero_tol_ff;
         endcase
      end

      case (op)
         gjsps_pkg::OP_SOLVE_INIT: begin
            n_in = n_eff;
            c_in = '0;
            i_in = '0;
            row_used_in = '0;
            best_in  = '0;
            found_in = 1'b0;
         end
         gjsps_pkg::OP_NEXT_ROW: i_in = CW'(i_ff + 1'b1);
         gjsps_pkg::OP_SCALE_INIT: begin
            scale_in = '0;
            j_in = c_ff;
         end
         gjsps_pkg::OP_SCALE_ACC: begin
            if (mag_rd > scale_ff) scale_in = mag_rd;
            j_in = CW'(j_ff + 1'b1);
         end
         gjsps_pkg::OP_RATIO_CMP: begin
            // strict compare keeps the first row on ties
            if (ratio > best_ff) begin
               best_in  = ratio;
               p_in     = i_ff;
               found_in = 1'b1;
            end
            i_in = CW'(i_ff + 1'b1);
         end
         gjsps_pkg::OP_PIVOT_TAKE: begin
            row_used_in[p_row] = 1'b1;
            i_in = '0;
         end
         gjsps_pkg::OP_LATCH_PIV: piv_in = ram_rdata;
         gjsps_pkg::OP_STEP_NEXT: begin
            c_in = CW'(c_ff + 1'b1);
            i_in = '0;
            best_in  = '0;
            found_in = 1'b0;
         end
         gjsps_pkg::OP_LATCH_F: begin
            f_in = ram_rdata;
            j_in = c_ff;
         end
         gjsps_pkg::OP_LATCH_PJ: prow_in = ram_rdata;
         gjsps_pkg::OP_MUL: begin
            elem_in = ram_rdata;
            prod_in = mag32(f_ff) * mag32(prow_ff);
            neg_in  = f_ff[VW-1] ^ prow_ff[VW-1] ^ piv_ff[VW-1];
         end
         gjsps_pkg::OP_ELIM_WRITE: j_in = CW'(j_ff + 1'b1);
         gjsps_pkg::OP_CLEAN_INIT: begin
            i_in = '0;
            j_in = '0;
            cnt_in = '0;
         end
         gjsps_pkg::OP_CL_CHECK: begin
            if (mag_rd > VW'(zero_tol_ff)) begin
               if (cnt_ff != 2'd2) cnt_in = 2'(cnt_ff + 1'b1);
               cur_col_in = j_ff;
            end
            j_in = CW'(j_ff + 1'b1);
         end
         gjsps_pkg::OP_CL_ROW_END: begin
            row_hit_in[i_row] = cnt_ff != '0;
            row_col_in[i_row] = cur_col_ff;
            i_in = CW'(i_ff + 1'b1);
            j_in = '0;
            cnt_in = '0;
         end
         gjsps_pkg::OP_FIN_INIT: i_in = '0;
         gjsps_pkg::OP_EMIT_NOUNK: begin
            rsp_valid_in = 1'b1;
            out_idx_in   = '0;
            out_val_in   = '0;
            out_st_in    = gjsps_pkg::ST_NO_UNKNOWN;
            out_last_in  = last_row;
            i_in = CW'(i_ff + 1'b1);
         end
         gjsps_pkg::OP_LATCH_RHS: rhs_in = ram_rdata;
         gjsps_pkg::OP_FIN_START: neg_in = rhs_ff[VW-1] ^ ram_rdata[VW-1];
         gjsps_pkg::OP_FIN_WRITE_RHS: begin
            rsp_valid_in = 1'b1;
            out_idx_in   = gjsps_pkg::ROW_FIELD_W'(row_col_ff[i_row]);
            out_val_in   = fin_res;
            out_st_in    = gjsps_pkg::ST_SOLVED;
            out_last_in  = last_row;
         end
         gjsps_pkg::OP_FIN_WRITE_COEF: i_in = CW'(i_ff + 1'b1);
         gjsps_pkg::OP_EMIT_SING: begin
            rsp_valid_in = 1'b1;
            out_idx_in   = '0;
            out_val_in   = '0;
            out_st_in    = gjsps_pkg::ST_SINGULAR;
            out_last_in  = 1'b1;
         end
         gjsps_pkg::OP_EMIT_NOANS: begin
            rsp_valid_in = 1'b1;
            out_idx_in   = '0;
            out_val_in   = '0;
            out_st_in    = gjsps_pkg::ST_NO_ANSWER;
            out_last_in  = 1'b1;
         end
         default: begin
            i_in = i_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unknown_count_ff <= gjsps_pkg::COUNT_W'(8);
         zero_tol_ff      <= '0;
         n_ff <= '0;
         i_ff <= '0;
         j_ff <= '0;
         c_ff <= '0;
         p_ff <= '0;
         row_used_ff  <= '0;
         row_hit_ff   <= '0;
         found_ff     <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unknown_count_ff <= unknown_count_in;
         zero_tol_ff      <= zero_tol_in;
         n_ff <= n_in;
         i_ff <= i_in;
         j_ff <= j_in;
         c_ff <= c_in;
         p_ff <= p_in;
         row_used_ff  <= row_used_in;
         row_hit_ff   <= row_hit_in;
         found_ff     <= found_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scale_ff    <= scale_in;
      best_ff     <= best_in;
      piv_ff      <= piv_in;
      f_ff        <= f_in;
      prow_ff     <= prow_in;
      elem_ff     <= elem_in;
      rhs_ff      <= rhs_in;
      prod_ff     <= prod_in;
      neg_ff      <= neg_in;
      cur_col_ff  <= cur_col_in;
      row_col_ff  <= row_col_in;
      out_idx_ff  <= out_idx_in;
      out_val_ff  <= out_val_in;
      out_st_ff   <= out_st_in;
      out_last_ff <= out_last_in;
   end

   always_comb begin
      status.i_end        = i_ff >= n_ff;
      status.j_end_coef   = j_ff >= n_ff;
      status.j_end_all    = j_ff > n_ff;
      status.row_used_cur = row_used_ff[i_row];
      status.row_is_pivot = i_ff == p_ff;
      status.last_step    = c_ff == CW'(n_ff - 1'b1);
      status.found        = found_ff;
      status.scale_zero   = scale_ff == '0;
      status.multi_coef   = cnt_ff == 2'd2;
      status.row_hit_cur  = row_hit_ff[i_row];
      status.div_busy     = div_busy;
      status.div_done     = div_done;
      status.out_busy     = out_busy;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_unknown_index  = out_idx_ff;
   assign rsp_solution_value = out_val_ff;
   assign rsp_status         = out_st_ff;
   assign rsp_last_result    = out_last_ff;

endmodule

FILE: design/gjsps_ctrl.sv
// Solver controller: sequences loads, pivot search, elimination, cleanup and results.
// Depends on gjsps_pkg and the assertion macro header.
`include "gauss_jordan_scaled_pivot_solver_macros.svh"
module gjsps_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_kind,
   input  gjsps_pkg::dp_status_type status,
   output gjsps_pkg::dp_op_type     op
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_PS_ROW,
      S_PS_RD,
      S_PS_SCALE,
      S_PS_WAITC,
      S_PS_DIV,
      S_PS_DONE,
      S_EL_PV,
      S_EL_PVW,
      S_EL_ROW,
      S_EL_FW,
      S_EL_RD,
      S_EL_RD2,
      S_EL_MUL,
      S_EL_DIVS,
      S_EL_DIV,
      S_CL_RD,
      S_CL_CHK,
      S_FN_ROW,
      S_FN_RW,
      S_FN_CW,
      S_FN_DIV,
      S_FN_WC,
      S_SING,
      S_NOANS
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = state_ff == S_IDLE;

   always_comb begin
      state_in = state_ff;
      op       = gjsps_pkg::OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_kind == gjsps_pkg::KIND_SOLVE) begin
                  op = gjsps_pkg::OP_SOLVE_INIT;
                  state_in = S_PS_ROW;
               end else begin
                  op = gjsps_pkg::OP_LOAD;
               end
            end
         end
         S_PS_ROW: begin
            if (status.i_end) begin
               state_in = S_PS_DONE;
            end else if (status.row_used_cur) begin
               op = gjsps_pkg::OP_NEXT_ROW;
            end else begin
               op = gjsps_pkg::OP_SCALE_INIT;
               state_in = S_PS_RD;
            end
         end
         S_PS_RD: begin
            if (status.j_end_coef) begin
               op = gjsps_pkg::OP_RD_IC;
               state_in = S_PS_WAITC;
            end else begin
               op = gjsps_pkg::OP_RD_IJ;
               state_in = S_PS_SCALE;
            end
         end
         S_PS_SCALE: begin
            op = gjsps_pkg::OP_SCALE_ACC;
            state_in = S_PS_RD;
         end
         S_PS_WAITC: begin
            op = gjsps_pkg::OP_RATIO_START;
            state_in = S_PS_DIV;
         end
         S_PS_DIV: begin
            if (status.scale_zero || status.div_done) begin
               op = gjsps_pkg::OP_RATIO_CMP;
               state_in = S_PS_ROW;
            end
         end
         S_PS_DONE: begin
            if (status.found) begin
               op = gjsps_pkg::OP_PIVOT_TAKE;
               state_in = S_EL_PV;
            end else begin
               state_in = S_SING;
            end
         end
         S_EL_PV: begin
            op = gjsps_pkg::OP_RD_PC;
            state_in = S_EL_PVW;
         end
         S_EL_PVW: begin
            op = gjsps_pkg::OP_LATCH_PIV;
            state_in = S_EL_ROW;
         end
         S_EL_ROW: begin
            if (status.i_end) begin
               if (status.last_step) begin
                  op = gjsps_pkg::OP_CLEAN_INIT;
                  state_in = S_CL_RD;
               end else begin
                  op = gjsps_pkg::OP_STEP_NEXT;
                  state_in = S_PS_ROW;
               end
            end else if (status.row_is_pivot) begin
               op = gjsps_pkg::OP_NEXT_ROW;
            end else begin
               op = gjsps_pkg::OP_RD_IC;
               state_in = S_EL_FW;
            end
         end
         S_EL_FW: begin
            op = gjsps_pkg::OP_LATCH_F;
            state_in = S_EL_RD;
         end
         S_EL_RD: begin
            if (status.j_end_all) begin
               op = gjsps_pkg::OP_NEXT_ROW;
               state_in = S_EL_ROW;
            end else begin
               op = gjsps_pkg::OP_RD_PJ;
               state_in = S_EL_RD2;
            end
         end
         S_EL_RD2: begin
            op = gjsps_pkg::OP_LATCH_PJ;
            state_in = S_EL_MUL;
         end
         S_EL_MUL: begin
            op = gjsps_pkg::OP_MUL;
            state_in = S_EL_DIVS;
         end
         S_EL_DIVS: begin
            op = gjsps_pkg::OP_ELIM_START;
            state_in = S_EL_DIV;
         end
         S_EL_DIV: begin
            if (status.div_done) begin
               op = gjsps_pkg::OP_ELIM_WRITE;
               state_in = S_EL_RD;
            end
         end
         S_CL_RD: begin
            if (status.i_end) begin
               op = gjsps_pkg::OP_FIN_INIT;
               state_in = S_FN_ROW;
            end else if (status.j_end_coef) begin
               if (status.multi_coef) begin
                  state_in = S_NOANS;
               end else begin
                  op = gjsps_pkg::OP_CL_ROW_END;
               end
            end else begin
               op = gjsps_pkg::OP_RD_IJ;
               state_in = S_CL_CHK;
            end
         end
         S_CL_CHK: begin
            op = gjsps_pkg::OP_CL_CHECK;
            state_in = S_CL_RD;
         end
         S_FN_ROW: begin
            if (status.i_end) begin
               state_in = S_IDLE;
            end else if (!status.row_hit_cur) begin
               if (!status.out_busy) op = gjsps_pkg::OP_EMIT_NOUNK;
            end else begin
               op = gjsps_pkg::OP_RD_IN;
               state_in = S_FN_RW;
            end
         end
         S_FN_RW: begin
            op = gjsps_pkg::OP_LATCH_RHS;
            state_in = S_FN_CW;
         end
         S_FN_CW: begin
            op = gjsps_pkg::OP_FIN_START;
            state_in = S_FN_DIV;
         end
         S_FN_DIV: begin
            if (status.div_done && !status.out_busy) begin
               op = gjsps_pkg::OP_FIN_WRITE_RHS;
               state_in = S_FN_WC;
            end
         end
         S_FN_WC: begin
            op = gjsps_pkg::OP_FIN_WRITE_COEF;
            state_in = S_FN_ROW;
         end
         S_SING: begin
            if (!status.out_busy) begin
               op = gjsps_pkg::OP_EMIT_SING;
               state_in = S_IDLE;
            end
         end
         S_NOANS: begin
            if (!status.out_busy) begin
               op = gjsps_pkg::OP_EMIT_NOANS;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `GJS_ASSERT(a_emit_room, clock, reset, (op == gjsps_pkg::OP_EMIT_SING || op == gjsps_pkg::OP_EMIT_NOANS || op == gjsps_pkg::OP_EMIT_NOUNK || op == gjsps_pkg::OP_FIN_WRITE_RHS) |-> !status.out_busy, "result emitted over a pending item")
   `GJS_ASSERT(a_div_idle, clock, reset, (op == gjsps_pkg::OP_ELIM_START || op == gjsps_pkg::OP_FIN_START) |-> !status.div_busy, "divider started while busy")
   `GJS_ASSERT(a_pivot_found, clock, reset, (op == gjsps_pkg::OP_PIVOT_TAKE) |-> status.found, "pivot taken without a candidate")

endmodule
